[sv/pdott_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pdott_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned ID_W     = 11;
  localparam int unsigned NODE_W   = 7;
  localparam int unsigned CAN_ID_W = 12;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IDX_W    = 3;
  // event threshold in us: 65535 ms * 1000 fits in 26 bits
  localparam int unsigned EVT_W    = 26;
  localparam int unsigned US_PER_MS = 1000;

  // transmission type codes
  localparam logic [7:0] TT_ACYCLIC    = 8'd0;
  localparam logic [7:0] TT_CYCLIC_MAX = 8'd240;
  localparam logic [7:0] TT_EVENT_MIN  = 8'd254;

  // sync kinds
  localparam logic [1:0] SYNC_NONE  = 2'd0;
  localparam logic [1:0] SYNC_PLAIN = 2'd1;
  localparam logic [1:0] SYNC_COUNT = 2'd2;

  typedef enum logic [IDX_W-1:0] {
    REG_TTYPE      = 3'd0,
    REG_INHIBIT    = 3'd1,
    REG_EVENT_MS   = 3'd2,
    REG_SYNC_START = 3'd3,
    REG_COB_BASE   = 3'd4,
    REG_NODE_ID    = 3'd5,
    REG_DATA_LEN   = 3'd6,
    REG_SPARE      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]        ttype;
    logic [TIME_W-1:0] inhibit_lim;
    logic [EVT_W-1:0]  event_thr;
    logic [7:0]        sync_start;
  } trig_cfg_t;

  typedef struct packed {
    logic en;  // byte is inside the mapped length
    logic wr;  // frame sent: capture the byte
  } lane_ctl_t;

endpackage
`default_nettype wire

[sv/pdott_byte_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
module pdott_byte_lane (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire pdott_pkg::lane_ctl_t      ctl,
  input  wire [pdott_pkg::BYTE_W-1:0]    data_byte,
  output logic                           diff,
  output logic [pdott_pkg::BYTE_W-1:0]   frame_byte
);

  logic [pdott_pkg::BYTE_W-1:0] last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (ctl.wr) begin
      last_r <= data_byte;
    end
  end

  assign diff       = ctl.en && (last_r != data_byte);
  assign frame_byte = ctl.en ? data_byte : '0;

endmodule
`default_nettype wire

[sv/pdott_trigger.sv]
`timescale 1ns / 1ps
`default_nettype none
module pdott_trigger (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            fire,
  input  wire pdott_pkg::trig_cfg_t      cfg,
  input  wire [1:0]                      sync_kind,
  input  wire [7:0]                      sync_count_in,
  input  wire [pdott_pkg::TIME_W-1:0]    elapsed_us,
  input  wire                            changed,
  output logic                           send
);

  localparam int unsigned TW = pdott_pkg::TIME_W;
  localparam int unsigned EW = pdott_pkg::EVT_W;

  logic [7:0]    sync_count_r, sync_count_nxt;
  logic          waiting_r, waiting_nxt;
  logic [TW-1:0] inhibit_r, inhibit_nxt;
  logic [EW-1:0] event_r, event_nxt;

  logic          is_sync, with_cnt, ws;
  logic [7:0]    cnt_inc;
  logic [TW:0]   inh_sum;
  logic [EW:0]   ev_sum;

  always_comb begin
    is_sync  = sync_kind != pdott_pkg::SYNC_NONE;
    with_cnt = sync_kind == pdott_pkg::SYNC_COUNT;
    cnt_inc  = sync_count_r + 8'd1;
    inh_sum  = {1'b0, inhibit_r} + {1'b0, elapsed_us};
    ev_sum   = {1'b0, event_r} + (EW+1)'(elapsed_us);

    send           = 1'b0;
    ws             = waiting_r;
    sync_count_nxt = sync_count_r;
    waiting_nxt    = waiting_r;
    inhibit_nxt    = inhibit_r;
    event_nxt      = event_r;

    if (cfg.ttype == pdott_pkg::TT_ACYCLIC) begin
      send = is_sync && changed;
    end else if (cfg.ttype <= pdott_pkg::TT_CYCLIC_MAX) begin
      if (is_sync) begin
        // the start value releases counting once it is seen
        if (ws && cfg.sync_start != 8'd0 && with_cnt && sync_count_in == cfg.sync_start) begin
          ws = 1'b0;
        end
        waiting_nxt = ws;
        if (!ws || cfg.sync_start == 8'd0 || !with_cnt) begin
          sync_count_nxt = cnt_inc;
          if (cfg.ttype <= cnt_inc) begin
            sync_count_nxt = 8'd0;
            send           = 1'b1;
            waiting_nxt    = 1'b1;
          end
        end
      end
    end else begin
      if (cfg.inhibit_lim != '0) begin
        if (inh_sum >= {1'b0, cfg.inhibit_lim}) begin
          if (changed) begin
            inhibit_nxt = '0;
            send        = 1'b1;
          end else begin
            inhibit_nxt = cfg.inhibit_lim;
          end
        end else begin
          inhibit_nxt = inh_sum[TW-1:0];
        end
      end else begin
        send = changed;
      end
      if (!send && cfg.event_thr != '0) begin
        if (ev_sum >= {1'b0, cfg.event_thr}) begin
          event_nxt = '0;
          send      = 1'b1;
        end else begin
          event_nxt = ev_sum[EW-1:0];
        end
      end
    end

    if (send) begin
      event_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_count_r <= '0;
      waiting_r    <= 1'b1;
      inhibit_r    <= '0;
      event_r      <= '0;
    end else if (fire) begin
      sync_count_r <= sync_count_nxt;
      waiting_r    <= waiting_nxt;
      inhibit_r    <= inhibit_nxt;
      event_r      <= event_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/pdo_transmit_trigger.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Handshake            Contents
// in_      in   in_tvalid/in_tready  one process tick: sync, elapsed time, mapped bytes
// out_     out  out_tvalid/out_tready one transmit frame, only when a send fires
// cfg_     in   cfg_we               register write, index and data
//
// One tick per cycle unless the output stalls: byte compare lanes, timers and the send
// decision settle in the accepting cycle, and the frame is registered on the next edge.
// A new tick is taken while a frame waits, as long as that frame leaves in the same cycle.
// Synchronous active-low reset clears config, output valid, timers and the last sent bytes.
// The event threshold in us is multiplied out when the register is written.
module pdo_transmit_trigger #(
  parameter int unsigned MAX_BYTES = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // [7:0] sync_count_in, [23:8] elapsed_us, [87:24] mapped_data
  input  wire  [87:0]  in_tdata,
  // [1:0] sync_kind
  input  wire  [1:0]   in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // [11:0] can_id, [15:12] dlc, [79:16] frame_data
  output logic [79:0]  out_tdata,
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);

  localparam int unsigned BW = pdott_pkg::BYTE_W;
  localparam int unsigned LW = pdott_pkg::LEN_W;
  localparam int unsigned NB = pdott_pkg::DATA_W / BW;

  pdott_pkg::trig_cfg_t              cfg_r;
  logic [pdott_pkg::ID_W-1:0]        cob_base_r;
  logic [pdott_pkg::NODE_W-1:0]      node_id_r;
  logic [LW-1:0]                     data_len_r;

  logic                              in_fire, send, changed;
  logic [LW-1:0]                     len_eff;
  logic [MAX_BYTES-1:0]              diff;
  logic [pdott_pkg::DATA_W-1:0]      frame;
  logic [pdott_pkg::DATA_W-1:0]      mapped_data;
  logic                              out_valid_r;
  logic [79:0]                       out_data_r;

  assign mapped_data = in_tdata[87:24];
  assign in_tready   = !out_valid_r || out_tready;
  assign in_fire     = in_tvalid && in_tready;
  assign len_eff     = (data_len_r > LW'(MAX_BYTES)) ? LW'(MAX_BYTES) : data_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= '0;
      cob_base_r <= '0;
      node_id_r  <= '0;
      data_len_r <= '0;
    end else if (cfg_we) begin
      unique case (pdott_pkg::reg_idx_t'(cfg_index))
        pdott_pkg::REG_TTYPE: begin
          // drop reserved types
          if (cfg_data[7:0] <= pdott_pkg::TT_CYCLIC_MAX ||
              cfg_data[7:0] >= pdott_pkg::TT_EVENT_MIN) begin
            cfg_r.ttype <= cfg_data[7:0];
          end
        end
        pdott_pkg::REG_INHIBIT:    cfg_r.inhibit_lim <= cfg_data;
        pdott_pkg::REG_EVENT_MS:   cfg_r.event_thr <=
            pdott_pkg::EVT_W'(cfg_data) * pdott_pkg::EVT_W'(pdott_pkg::US_PER_MS);
        pdott_pkg::REG_SYNC_START: cfg_r.sync_start <= cfg_data[7:0];
        pdott_pkg::REG_COB_BASE:   cob_base_r <= cfg_data[pdott_pkg::ID_W-1:0];
        pdott_pkg::REG_NODE_ID:    node_id_r <= cfg_data[pdott_pkg::NODE_W-1:0];
        pdott_pkg::REG_DATA_LEN:   data_len_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_lane
    if (i < MAX_BYTES) begin : g_act
      pdott_pkg::lane_ctl_t ctl;
      assign ctl.en = LW'(i) < len_eff;
      assign ctl.wr = in_fire && send && ctl.en;
      pdott_byte_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .data_byte  (mapped_data[BW*i +: BW]),
        .diff       (diff[i]),
        .frame_byte (frame[BW*i +: BW])
      );
    end else begin : g_off
      assign frame[BW*i +: BW] = '0;
    end
  end

  // merge the lane compares
  assign changed = |diff;

  pdott_trigger u_trigger (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (in_fire),
    .cfg           (cfg_r),
    .sync_kind     (in_tuser),
    .sync_count_in (in_tdata[7:0]),
    .elapsed_us    (in_tdata[23:8]),
    .changed       (changed),
    .send          (send)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= send;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && send) begin
      out_data_r <= {frame, len_eff,
                     pdott_pkg::CAN_ID_W'(cob_base_r) + pdott_pkg::CAN_ID_W'(node_id_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
